[hw/rtl/adam_pkg.sv]
`timescale 1ns / 1ps

package adam_pkg;

  localparam logic DSU_DIV  = 1'b0;
  localparam logic DSU_SQRT = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } dsu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } dsu_stat_t;

  localparam int DSU_HI_W  = 56;
  localparam int DSU_LO_W  = 48;
  localparam int DSU_DEN_W = 49;
  localparam int DSU_CNT_W = 6;

  localparam logic [DSU_CNT_W-1:0] Q_MOMENT   = 6'd48;
  localparam logic [DSU_CNT_W-1:0] Q_RATIO    = 6'd32;
  localparam logic [DSU_CNT_W-1:0] SQRT_STEPS = 6'd32;
  localparam logic [63:0]          SQRT_BIT0  = 64'h4000_0000_0000_0000;

  localparam logic [1:0] REG_LR  = 2'd0;
  localparam logic [1:0] REG_B1  = 2'd1;
  localparam logic [1:0] REG_B2  = 2'd2;
  localparam logic [1:0] REG_EPS = 2'd3;

  localparam logic [31:0] LR_RESET  = 32'd16777;
  localparam logic [15:0] B1_RESET  = 16'd58982;
  localparam logic [15:0] B2_RESET  = 16'd65470;
  localparam logic [31:0] EPS_RESET = 32'd43;

  localparam logic [31:0] POW_ONE   = 32'hFFFF_FFFF;
  localparam logic [16:0] ONE_Q16   = 17'h1_0000;
  localparam logic [47:0] MHAT_CAP  = 48'h8000_0000_0000;
  localparam logic [47:0] VHAT_CAP  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] RATIO_CAP = 32'hFFFF_FFFF;

endpackage

[hw/rtl/adam_mul.sv]
`timescale 1ns / 1ps

module adam_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(a) * 64'(b);
  end

  assign prod = prod_r;

endmodule

[hw/rtl/adam_dsu.sv]
`timescale 1ns / 1ps

// restoring divide (one quotient bit per cycle) and bitwise isqrt (one root bit per cycle)
module adam_dsu (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  adam_pkg::dsu_cmd_t                   cmd,
  input  logic [adam_pkg::DSU_HI_W-1:0]        hi,
  input  logic [adam_pkg::DSU_LO_W-1:0]        lo,
  input  logic [adam_pkg::DSU_DEN_W-1:0]       den,
  input  logic [adam_pkg::DSU_CNT_W-1:0]       nbits,
  input  logic [63:0]                          sq_n,
  output adam_pkg::dsu_stat_t                  stat,
  output logic [47:0]                          quo,
  output logic [31:0]                          root
);

  logic                               busy_r;
  logic                               done_r;
  logic                               sat_r;
  logic                               mode_r;
  logic [adam_pkg::DSU_CNT_W-1:0]     cnt_r;
  logic [adam_pkg::DSU_DEN_W-1:0]     rem_r;
  logic [adam_pkg::DSU_DEN_W-1:0]     den_r;
  logic [adam_pkg::DSU_LO_W-1:0]      lo_r;
  logic [47:0]                        q_r;
  logic [63:0]                        n_r;
  logic [63:0]                        res_r;
  logic [63:0]                        bit_r;

  logic                               hi_ge;
  logic [adam_pkg::DSU_DEN_W:0]       t;
  logic [adam_pkg::DSU_DEN_W:0]       tsub;
  logic                               dge;
  logic [63:0]                        rb;
  logic                               sge;

  always_comb begin
    hi_ge = hi >= adam_pkg::DSU_HI_W'(den);
    t     = {rem_r, lo_r[adam_pkg::DSU_LO_W-1]};
    tsub  = t - {1'b0, den_r};
    dge   = t >= {1'b0, den_r};
    rb    = res_r + bit_r;
    sge   = n_r >= rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        if (cmd.mode == adam_pkg::DSU_DIV && hi_ge) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == adam_pkg::DSU_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= cmd.mode;
      q_r    <= '0;
      if (cmd.mode == adam_pkg::DSU_DIV) begin
        sat_r <= hi_ge;
        den_r <= den;
        lo_r  <= lo;
        rem_r <= hi[adam_pkg::DSU_DEN_W-1:0];
        cnt_r <= nbits;
      end else begin
        sat_r <= 1'b0;
        n_r   <= sq_n;
        res_r <= '0;
        bit_r <= adam_pkg::SQRT_BIT0;
        cnt_r <= adam_pkg::SQRT_STEPS;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - adam_pkg::DSU_CNT_W'(1);
      if (mode_r == adam_pkg::DSU_DIV) begin
        q_r   <= {q_r[46:0], dge};
        rem_r <= dge ? tsub[adam_pkg::DSU_DEN_W-1:0] : t[adam_pkg::DSU_DEN_W-1:0];
        lo_r  <= {lo_r[adam_pkg::DSU_LO_W-2:0], 1'b0};
      end else begin
        if (sge) begin
          n_r   <= n_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign stat = '{busy: busy_r, done: done_r, sat: sat_r};
  assign quo  = q_r;
  assign root = res_r[31:0];

endmodule

[hw/rtl/adam_optimizer_update.sv]
`timescale 1ns / 1ps

// Adam update of one parameter element per item, fixed point. After reset the moment stores
// are cleared, one entry per cycle; in_ready stays low meanwhile while register writes are
// taken. Items are then handled one at a time: the index reduction, the shared 32x32
// multiplier for beta powers and moments, the two bias-correction divides, the square root
// and the final divide (skipped when its denominator is zero), all on one bit-per-cycle
// divide/root unit, then the step and output, and a return to idle before the next item; a
// stalled output holds the block in its last step.

module adam_optimizer_update #(
  parameter int ELEMENTS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_param_value,
  input  logic [31:0] in_gradient,
  input  logic [11:0] in_element_index,
  input  logic        in_step_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_new_value,
  output logic [11:0] out_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam logic [32:0] ADDR_RECIP =
    33'(((64'd1 << 32) + 64'(ELEMENTS) - 64'd1) / 64'(ELEMENTS));

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_ADDR = 5'd2;
  localparam logic [4:0] S_M0   = 5'd3;
  localparam logic [4:0] S_M1   = 5'd4;
  localparam logic [4:0] S_M2   = 5'd5;
  localparam logic [4:0] S_M3   = 5'd6;
  localparam logic [4:0] S_M4   = 5'd7;
  localparam logic [4:0] S_M5   = 5'd8;
  localparam logic [4:0] S_M6   = 5'd9;
  localparam logic [4:0] S_M7   = 5'd10;
  localparam logic [4:0] S_M8   = 5'd11;
  localparam logic [4:0] S_M9   = 5'd12;
  localparam logic [4:0] S_M10  = 5'd13;
  localparam logic [4:0] S_DIV1 = 5'd14;
  localparam logic [4:0] S_DIV2 = 5'd15;
  localparam logic [4:0] S_SQRT = 5'd16;
  localparam logic [4:0] S_DIV3 = 5'd17;
  localparam logic [4:0] S_LR   = 5'd18;
  localparam logic [4:0] S_LR2  = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  logic [4:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r;

  logic [31:0]        lr_r;
  logic [15:0]        b1_r;
  logic [15:0]        b2_r;
  logic [31:0]        eps_r;

  logic [31:0]        p_r;
  logic [31:0]        g_r;
  logic [11:0]        idx_r;
  logic               ss_r;
  logic [11:0]        addr_quo_r;
  logic [AW-1:0]      addr_r;

  logic [31:0]        pw1_r;
  logic [31:0]        pw2_r;
  logic [31:0]        step_cnt_r;

  logic signed [65:0] acc_r;
  logic [31:0]        m_r;
  logic [47:0]        g2_r;
  logic [47:0]        v_r;
  logic [47:0]        mhat_r;
  logic [31:0]        ratio_r;
  logic [31:0]        fin_r;

  logic [31:0]        fm_mem [ELEMENTS];
  logic [47:0]        sm_mem [ELEMENTS];
  logic [31:0]        fm_rd_r;
  logic [47:0]        sm_rd_r;

  logic               out_valid_r;
  logic [31:0]        out_value_r;
  logic [11:0]        out_index_r;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;

  adam_pkg::dsu_cmd_t                  dsu_cmd;
  adam_pkg::dsu_stat_t                 dsu_stat;
  logic [adam_pkg::DSU_HI_W-1:0]       dsu_hi;
  logic [adam_pkg::DSU_LO_W-1:0]       dsu_lo;
  logic [adam_pkg::DSU_DEN_W-1:0]      dsu_den;
  logic [adam_pkg::DSU_CNT_W-1:0]      dsu_nbits;
  logic [63:0]                         dsu_sq_n;
  logic [47:0]                         dsu_quo;
  logic [31:0]                         dsu_root;

  logic               accept;
  logic               cfg_wr;
  logic [44:0]        addr_prod;
  logic [32:0]        addr_full;
  logic [31:0]        fm_abs, g_abs, m_abs;
  logic [32:0]        c1, c2;
  logic [16:0]        b1c, b2c;
  logic [47:0]        vhat_c;
  logic [48:0]        den_c;
  logic [64:0]        rnd;
  logic signed [34:0] res_c;
  logic [31:0]        res_sat;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        fm_wdata;
  logic [47:0]        sm_wdata;

  adam_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  adam_dsu u_dsu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (dsu_cmd),
    .hi    (dsu_hi),
    .lo    (dsu_lo),
    .den   (dsu_den),
    .nbits (dsu_nbits),
    .sq_n  (dsu_sq_n),
    .stat  (dsu_stat),
    .quo   (dsu_quo),
    .root  (dsu_root)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = state_r == S_IDLE;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_comb begin
    case (paddr[3:2])
      adam_pkg::REG_LR:  prdata = lr_r;
      adam_pkg::REG_B1:  prdata = {16'b0, b1_r};
      adam_pkg::REG_B2:  prdata = {16'b0, b2_r};
      adam_pkg::REG_EPS: prdata = eps_r;
      default:           prdata = '0;
    endcase
  end

  // index modulo ELEMENTS by reciprocal multiply, quotient taken at accept
  always_comb begin
    addr_prod = 45'(in_element_index) * 45'(ADDR_RECIP);
    addr_full = 33'(idx_r) - 33'(addr_quo_r) * 33'(ELEMENTS);
  end

  always_comb begin
    fm_abs  = fm_rd_r[31] ? (~fm_rd_r + 32'd1) : fm_rd_r;
    g_abs   = g_r[31] ? (~g_r + 32'd1) : g_r;
    m_abs   = m_r[31] ? (~m_r + 32'd1) : m_r;
    b1c     = adam_pkg::ONE_Q16 - {1'b0, b1_r};
    b2c     = adam_pkg::ONE_Q16 - {1'b0, b2_r};
    c1      = 33'h1_0000_0000 - {1'b0, pw1_r};
    c2      = 33'h1_0000_0000 - {1'b0, pw2_r};
    vhat_c  = dsu_stat.sat ? adam_pkg::VHAT_CAP : dsu_quo;
    den_c   = {1'b0, dsu_root, 16'b0} + {17'b0, eps_r};
    rnd     = {1'b0, prod} + 65'h8000_0000;
    res_c   = m_r[31] ? ($signed({{3{p_r[31]}}, p_r}) + $signed({2'b0, rnd[64:32]}))
                      : ($signed({{3{p_r[31]}}, p_r}) - $signed({2'b0, rnd[64:32]}));
    if (res_c > 35'sd2147483647) begin
      res_sat = 32'h7FFF_FFFF;
    end else if (res_c < -35'sd2147483648) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = res_c[31:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M0: begin
        mul_a = pw1_r;
        mul_b = {16'b0, b1_r};
      end
      S_M1: begin
        mul_a = pw2_r;
        mul_b = {16'b0, b2_r};
      end
      S_M2: begin
        mul_a = fm_abs;
        mul_b = {16'b0, b1_r};
      end
      S_M3: begin
        mul_a = g_abs;
        mul_b = {15'b0, b1c};
      end
      S_M4: begin
        mul_a = g_abs;
        mul_b = g_abs;
      end
      S_M5: begin
        mul_a = sm_rd_r[31:0];
        mul_b = {16'b0, b2_r};
      end
      S_M6: begin
        mul_a = {16'b0, sm_rd_r[47:32]};
        mul_b = {16'b0, b2_r};
      end
      S_M7: begin
        mul_a = g2_r[31:0];
        mul_b = {15'b0, b2c};
      end
      S_M8: begin
        mul_a = {16'b0, g2_r[47:32]};
        mul_b = {15'b0, b2c};
      end
      S_LR: begin
        mul_a = lr_r;
        mul_b = ratio_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    dsu_cmd   = '{start: 1'b0, mode: adam_pkg::DSU_DIV};
    dsu_hi    = '0;
    dsu_lo    = '0;
    dsu_den   = '0;
    dsu_nbits = adam_pkg::Q_MOMENT;
    dsu_sq_n  = '0;
    case (state_r)
      S_M10: begin
        dsu_cmd.start = 1'b1;
        dsu_hi        = {40'b0, m_abs[31:16]};
        dsu_lo        = {m_abs[15:0], 32'b0};
        dsu_den       = {16'b0, c1};
      end
      S_DIV1: begin
        dsu_cmd.start = dsu_stat.done;
        dsu_hi        = {24'b0, v_r[47:16]};
        dsu_lo        = {v_r[15:0], 32'b0};
        dsu_den       = {16'b0, c2};
      end
      S_DIV2: begin
        dsu_cmd.start = dsu_stat.done;
        dsu_cmd.mode  = adam_pkg::DSU_SQRT;
        dsu_sq_n      = {vhat_c, 16'b0};
      end
      S_SQRT: begin
        dsu_cmd.start = dsu_stat.done && (den_c != '0);
        dsu_hi        = {mhat_r, 8'b0};
        dsu_den       = den_c;
        dsu_nbits     = adam_pkg::Q_RATIO;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:   if (clr_addr_r == AW'(ELEMENTS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_M0;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_M6;
      S_M6:    state_nxt = S_M7;
      S_M7:    state_nxt = S_M8;
      S_M8:    state_nxt = S_M9;
      S_M9:    state_nxt = S_M10;
      S_M10:   state_nxt = S_DIV1;
      S_DIV1:  if (dsu_stat.done) state_nxt = S_DIV2;
      S_DIV2:  if (dsu_stat.done) state_nxt = S_SQRT;
      S_SQRT: begin
        if (dsu_stat.done) state_nxt = (den_c == '0) ? S_LR : S_DIV3;
      end
      S_DIV3:  if (dsu_stat.done) state_nxt = S_LR;
      S_LR:    state_nxt = S_LR2;
      S_LR2:   state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      lr_r        <= adam_pkg::LR_RESET;
      b1_r        <= adam_pkg::B1_RESET;
      b2_r        <= adam_pkg::B2_RESET;
      eps_r       <= adam_pkg::EPS_RESET;
      pw1_r       <= adam_pkg::POW_ONE;
      pw2_r       <= adam_pkg::POW_ONE;
      step_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_wr) begin
        case (paddr[3:2])
          adam_pkg::REG_LR:  lr_r  <= pwdata;
          adam_pkg::REG_B1:  b1_r  <= pwdata[15:0];
          adam_pkg::REG_B2:  b2_r  <= pwdata[15:0];
          adam_pkg::REG_EPS: eps_r <= pwdata;
          default: ;
        endcase
      end
      if (state_r == S_M1 && ss_r) pw1_r <= prod[47:16];
      if (state_r == S_M2 && ss_r) begin
        pw2_r <= prod[47:16];
        if (step_cnt_r != 32'hFFFF_FFFF) step_cnt_r <= step_cnt_r + 32'd1;
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r        <= in_param_value;
      g_r        <= in_gradient;
      idx_r      <= in_element_index;
      ss_r       <= in_step_start;
      addr_quo_r <= addr_prod[43:32];
    end
    if (state_r == S_ADDR) addr_r <= addr_full[AW-1:0];
    case (state_r)
      S_M3:   acc_r <= fm_rd_r[31] ? -$signed({2'b0, prod}) : $signed({2'b0, prod});
      S_M4:   acc_r <= g_r[31] ? (acc_r - $signed({2'b0, prod}))
                               : (acc_r + $signed({2'b0, prod}));
      S_M5: begin
        m_r   <= acc_r[47:16];
        g2_r  <= prod[63:16];
      end
      S_M6:   acc_r <= $signed({2'b0, prod});
      S_M7:   acc_r <= acc_r + $signed({prod[33:0], 32'b0});
      S_M8:   acc_r <= acc_r + $signed({2'b0, prod});
      S_M9:   acc_r <= acc_r + $signed({prod[33:0], 32'b0});
      S_M10:  v_r   <= acc_r[63:16];
      S_DIV1: begin
        if (dsu_stat.done) begin
          mhat_r <= (dsu_stat.sat || dsu_quo > adam_pkg::MHAT_CAP) ? adam_pkg::MHAT_CAP
                                                                   : dsu_quo;
        end
      end
      S_SQRT: begin
        if (dsu_stat.done && den_c == '0) begin
          ratio_r <= (mhat_r == '0) ? '0 : adam_pkg::RATIO_CAP;
        end
      end
      S_DIV3: begin
        if (dsu_stat.done) ratio_r <= dsu_stat.sat ? adam_pkg::RATIO_CAP : dsu_quo[31:0];
      end
      S_LR2:  fin_r <= res_sat;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_value_r <= fin_r;
          out_index_r <= idx_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = (state_r == S_CLR) || (state_r == S_M10);
    mem_re    = state_r == S_M0;
    mem_waddr = (state_r == S_CLR) ? clr_addr_r : addr_r;
    fm_wdata  = (state_r == S_CLR) ? '0 : m_r;
    sm_wdata  = (state_r == S_CLR) ? '0 : acc_r[63:16];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fm_mem[mem_waddr] <= fm_wdata;
      sm_mem[mem_waddr] <= sm_wdata;
    end
    if (mem_re) begin
      fm_rd_r <= fm_mem[addr_r];
      sm_rd_r <= sm_mem[addr_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_value_r;
  assign out_index     = out_index_r;

endmodule
